[src/fec_group_window_tracker_defines.svh]
// ----------------------------------------------------------------------------
// fec group window tracker assertion macros
// shared concurrent assertion forms, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef FEC_GROUP_WINDOW_TRACKER_DEFINES_SVH
`define FEC_GROUP_WINDOW_TRACKER_DEFINES_SVH

// same-cycle implication
`define FGWT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FGWT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/fgwt_pkg.sv]
// ----------------------------------------------------------------------------
// fgwt_pkg
// shared constants, types and helpers of the fec group window tracker
// ----------------------------------------------------------------------------
package fgwt_pkg;

	localparam int WINDOW_GROUPS = 4;
	localparam int CODE_N        = 8;
	localparam int CODE_K        = 6;
	localparam int MARK_DEPTH    = 64;

	localparam int NSLOTS     = WINDOW_GROUPS + 1;
	localparam int NWORK      = NSLOTS + 1;
	localparam int GROUP_W    = 32;
	localparam int IDX_W      = 3;
	localparam int MASK_W     = 1 << IDX_W;
	localparam int COUNT_W    = $clog2(MASK_W + 1);
	localparam int ACT_W      = 3;
	localparam int CNT_W      = $clog2(NWORK + 1);
	localparam int POS_W      = $clog2(NWORK);
	localparam int MARK_IDX_W = $clog2(MARK_DEPTH);

	typedef logic [GROUP_W-1:0] group_t;
	typedef logic [MASK_W-1:0]  mask_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [POS_W-1:0]   pos_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_STORED         = 3'd0,
		ACT_DROP_STALE     = 3'd1,
		ACT_DROP_FINISHED  = 3'd2,
		ACT_RELEASED       = 3'd3,
		ACT_DISCARDED      = 3'd4,
		ACT_FLUSH_DONE     = 3'd5
	} action_t;

	// which word the datapath builds on an emit command
	typedef enum logic [2:0] {
		SRC_STALE,
		SRC_FINISHED,
		SRC_STORED,
		SRC_HEAD,
		SRC_FULL,
		SRC_FLUSH_DONE
	} src_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_STORE,
		ST_EVICT,
		ST_RELEASE,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic latch;
		logic update;
		logic emit;
		src_t src;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic flush;
		logic stale;
		logic finished;
		logic evict;
		logic full_any;
		logic empty;
		logic can_emit;
		logic out_free;
	} status_t;

	function automatic count_t count_bits(input mask_t m);
		count_t c;
		c = '0;
		for (int i = 0; i < MASK_W; i++) begin
			c = c + count_t'(m[i]);
		end
		return c;
	endfunction

endpackage

[src/fgwt_ctrl.sv]
// ----------------------------------------------------------------------------
// fgwt_ctrl
// sequencer: steps one item through check, store, evict, release or flush
// ----------------------------------------------------------------------------
module fgwt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  fgwt_pkg::status_t status,
	output fgwt_pkg::cmd_t    cmd
);

	fgwt_pkg::state_t state_q;
	fgwt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fgwt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fgwt_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = fgwt_pkg::ST_CHECK;
				end
			end
			fgwt_pkg::ST_CHECK: begin
				if (status.flush) begin
					state_d = fgwt_pkg::ST_FLUSH;
				end else if (status.stale || status.finished) begin
					if (status.can_emit) begin
						state_d = fgwt_pkg::ST_FINISH;
					end
				end else begin
					state_d = fgwt_pkg::ST_STORE;
				end
			end
			fgwt_pkg::ST_STORE: begin
				if (status.can_emit) begin
					state_d = fgwt_pkg::ST_EVICT;
				end
			end
			fgwt_pkg::ST_EVICT: begin
				if (!status.evict) begin
					state_d = fgwt_pkg::ST_RELEASE;
				end
			end
			fgwt_pkg::ST_RELEASE: begin
				if (!status.full_any) begin
					state_d = fgwt_pkg::ST_FINISH;
				end
			end
			fgwt_pkg::ST_FLUSH: begin
				if (status.empty && status.can_emit) begin
					state_d = fgwt_pkg::ST_FINISH;
				end
			end
			fgwt_pkg::ST_FINISH: begin
				if (status.out_free) begin
					state_d = fgwt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fgwt_pkg::ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd        = '0;
		cmd.src    = fgwt_pkg::SRC_STALE;
		item_ready = 1'b0;
		case (state_q)
			fgwt_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				cmd.latch  = item_valid;
			end
			fgwt_pkg::ST_CHECK: begin
				if (!status.flush) begin
					if (status.stale) begin
						cmd.emit = status.can_emit;
						cmd.src  = fgwt_pkg::SRC_STALE;
					end else if (status.finished) begin
						cmd.emit = status.can_emit;
						cmd.src  = fgwt_pkg::SRC_FINISHED;
					end else begin
						cmd.update = 1'b1;
					end
				end
			end
			fgwt_pkg::ST_STORE: begin
				cmd.emit = status.can_emit;
				cmd.src  = fgwt_pkg::SRC_STORED;
			end
			fgwt_pkg::ST_EVICT: begin
				cmd.emit = status.evict && status.can_emit;
				cmd.src  = fgwt_pkg::SRC_HEAD;
			end
			fgwt_pkg::ST_RELEASE: begin
				cmd.emit = status.full_any && status.can_emit;
				cmd.src  = fgwt_pkg::SRC_FULL;
			end
			fgwt_pkg::ST_FLUSH: begin
				cmd.emit = status.can_emit;
				cmd.src  = status.empty ? fgwt_pkg::SRC_FLUSH_DONE : fgwt_pkg::SRC_HEAD;
			end
			fgwt_pkg::ST_FINISH: begin
				cmd.finish = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[src/fgwt_datapath.sv]
// ----------------------------------------------------------------------------
// fgwt_datapath
// sorted group table, finished window, word hold stage and output register
// ----------------------------------------------------------------------------
module fgwt_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fgwt_pkg::cmd_t                 cmd,
	output fgwt_pkg::status_t              status,
	input  logic                           operation,
	input  logic [fgwt_pkg::GROUP_W-1:0]   packet_group,
	input  logic [fgwt_pkg::IDX_W-1:0]     packet_index,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [fgwt_pkg::ACT_W-1:0]     action,
	output logic [fgwt_pkg::GROUP_W-1:0]   result_group,
	output logic [fgwt_pkg::MASK_W-1:0]    present_mask,
	output logic [fgwt_pkg::COUNT_W-1:0]   present_count,
	output logic                           last
);

	// latched item
	logic                       op_q;
	fgwt_pkg::group_t           gid_q;
	logic [fgwt_pkg::IDX_W-1:0] idx_q;

	// table, kept sorted by group id, valid below cnt_q
	fgwt_pkg::group_t grp_q [fgwt_pkg::NWORK];
	fgwt_pkg::mask_t  msk_q [fgwt_pkg::NWORK];
	fgwt_pkg::group_t grp_d [fgwt_pkg::NWORK];
	fgwt_pkg::mask_t  msk_d [fgwt_pkg::NWORK];
	fgwt_pkg::cnt_t   cnt_q;
	fgwt_pkg::pos_t   pos_q;

	fgwt_pkg::group_t              newest_q;
	logic [fgwt_pkg::MARK_DEPTH-1:0] marks_q;
	logic                          seen_q;

	logic              hold_valid_q;
	fgwt_pkg::action_t hold_act_q;
	fgwt_pkg::group_t  hold_grp_q;
	fgwt_pkg::mask_t   hold_msk_q;

	logic              res_valid_q;
	fgwt_pkg::action_t res_act_q;
	fgwt_pkg::group_t  res_grp_q;
	fgwt_pkg::mask_t   res_msk_q;
	fgwt_pkg::count_t  res_cnt_q;
	logic              res_last_q;

	logic [fgwt_pkg::NWORK-1:0] live;
	logic [fgwt_pkg::NWORK-1:0] hit_vec;
	logic [fgwt_pkg::NWORK-1:0] lt_vec;
	logic [fgwt_pkg::NWORK-1:0] full_vec;
	logic                       hit;
	fgwt_pkg::pos_t             hit_pos;
	fgwt_pkg::pos_t             ins_pos;
	fgwt_pkg::pos_t             full_idx;
	fgwt_pkg::pos_t             rm_idx;
	fgwt_pkg::group_t           last_grp;
	fgwt_pkg::group_t           span;
	fgwt_pkg::group_t           dist_new;
	fgwt_pkg::group_t           rise;
	fgwt_pkg::group_t           rm_dist;
	logic                       fin_raw;
	logic                       stale;
	logic                       newer;
	logic                       evict;
	fgwt_pkg::mask_t            idx_bit;
	logic                       head_release;
	fgwt_pkg::action_t          em_act;
	fgwt_pkg::group_t           em_grp;
	fgwt_pkg::mask_t            em_msk;
	logic                       remove;
	logic                       mark_hit;
	logic                       push;
	logic                       out_free;

	// table lookups
	always_comb begin
		hit_pos  = '0;
		full_idx = '0;
		ins_pos  = '0;
		last_grp = grp_q[0];
		for (int j = 0; j < fgwt_pkg::NWORK; j++) begin
			live[j]     = fgwt_pkg::cnt_t'(j) < cnt_q;
			hit_vec[j]  = live[j] && (grp_q[j] == gid_q);
			lt_vec[j]   = live[j] && (grp_q[j] < gid_q);
			full_vec[j] = live[j] &&
				(fgwt_pkg::count_bits(msk_q[j]) >= fgwt_pkg::count_t'(fgwt_pkg::CODE_N));
			ins_pos     = ins_pos + fgwt_pkg::pos_t'(lt_vec[j]);
			if (fgwt_pkg::cnt_t'(j + 1) == cnt_q) begin
				last_grp = grp_q[j];
			end
		end
		for (int j = fgwt_pkg::NWORK - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hit_pos = fgwt_pkg::pos_t'(j);
			end
			if (full_vec[j]) begin
				full_idx = fgwt_pkg::pos_t'(j);
			end
		end
	end

	assign hit          = |hit_vec;
	assign span         = last_grp - grp_q[0];
	assign evict        = (cnt_q > fgwt_pkg::cnt_t'(1)) &&
		(span > fgwt_pkg::group_t'(fgwt_pkg::WINDOW_GROUPS));
	assign dist_new     = newest_q - gid_q;
	assign fin_raw      = seen_q && (gid_q <= newest_q) &&
		((dist_new >= fgwt_pkg::group_t'(fgwt_pkg::MARK_DEPTH)) ||
		 marks_q[dist_new[fgwt_pkg::MARK_IDX_W-1:0]]);
	assign stale        = (cnt_q >= fgwt_pkg::cnt_t'(fgwt_pkg::WINDOW_GROUPS)) &&
		(cnt_q != '0) && (gid_q < grp_q[0]);
	assign newer        = !seen_q || (gid_q > newest_q);
	assign rise         = gid_q - newest_q;
	assign idx_bit      = fgwt_pkg::mask_t'(1) << idx_q;
	assign head_release = fgwt_pkg::count_bits(msk_q[0]) >=
		fgwt_pkg::count_t'(fgwt_pkg::CODE_K);

	// word selection
	always_comb begin
		em_act = fgwt_pkg::ACT_DROP_STALE;
		em_grp = gid_q;
		em_msk = '0;
		case (cmd.src)
			fgwt_pkg::SRC_STALE: begin
				em_act = fgwt_pkg::ACT_DROP_STALE;
			end
			fgwt_pkg::SRC_FINISHED: begin
				em_act = fgwt_pkg::ACT_DROP_FINISHED;
			end
			fgwt_pkg::SRC_STORED: begin
				em_act = fgwt_pkg::ACT_STORED;
				em_msk = msk_q[pos_q];
			end
			fgwt_pkg::SRC_HEAD: begin
				em_act = head_release ? fgwt_pkg::ACT_RELEASED : fgwt_pkg::ACT_DISCARDED;
				em_grp = grp_q[0];
				em_msk = msk_q[0];
			end
			fgwt_pkg::SRC_FULL: begin
				em_act = fgwt_pkg::ACT_RELEASED;
				em_grp = grp_q[full_idx];
				em_msk = msk_q[full_idx];
			end
			fgwt_pkg::SRC_FLUSH_DONE: begin
				em_act = fgwt_pkg::ACT_FLUSH_DONE;
				em_grp = '0;
			end
			default: begin
				em_act = fgwt_pkg::ACT_DROP_STALE;
			end
		endcase
	end

	assign remove   = cmd.emit &&
		((cmd.src == fgwt_pkg::SRC_HEAD) || (cmd.src == fgwt_pkg::SRC_FULL));
	assign rm_idx   = (cmd.src == fgwt_pkg::SRC_FULL) ? full_idx : '0;
	assign rm_dist  = newest_q - em_grp;
	assign mark_hit = seen_q && (em_grp <= newest_q) &&
		(rm_dist < fgwt_pkg::group_t'(fgwt_pkg::MARK_DEPTH));

	// table next value: sorted insert or removal with close-up
	always_comb begin
		grp_d = grp_q;
		msk_d = msk_q;
		if (cmd.update) begin
			if (hit) begin
				msk_d[hit_pos] = msk_q[hit_pos] | idx_bit;
			end else begin
				for (int j = 1; j < fgwt_pkg::NWORK; j++) begin
					if (fgwt_pkg::pos_t'(j) > ins_pos) begin
						grp_d[j] = grp_q[j-1];
						msk_d[j] = msk_q[j-1];
					end
				end
				grp_d[ins_pos] = gid_q;
				msk_d[ins_pos] = idx_bit;
			end
		end else if (remove) begin
			for (int j = 0; j < fgwt_pkg::NWORK - 1; j++) begin
				if (fgwt_pkg::pos_t'(j) >= rm_idx) begin
					grp_d[j] = grp_q[j+1];
					msk_d[j] = msk_q[j+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_q <= grp_d;
		msk_q <= msk_d;
		if (cmd.latch) begin
			op_q  <= operation;
			gid_q <= packet_group;
			idx_q <= packet_index;
		end
		if (cmd.update) begin
			pos_q <= hit ? hit_pos : ins_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.update && !hit) begin
			cnt_q <= cnt_q + fgwt_pkg::cnt_t'(1);
		end else if (remove) begin
			cnt_q <= cnt_q - fgwt_pkg::cnt_t'(1);
		end
	end

	// newest id and finished window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			marks_q  <= '0;
			seen_q   <= 1'b0;
		end else if (cmd.update && newer) begin
			newest_q <= gid_q;
			seen_q   <= 1'b1;
			if (!seen_q || (rise >= fgwt_pkg::group_t'(fgwt_pkg::MARK_DEPTH))) begin
				marks_q <= '0;
			end else begin
				marks_q <= marks_q << rise[fgwt_pkg::MARK_IDX_W-1:0];
			end
		end else if (remove && mark_hit) begin
			marks_q[rm_dist[fgwt_pkg::MARK_IDX_W-1:0]] <= 1'b1;
		end
	end

	// hold stage: a word goes out once its successor or the end is known
	assign out_free = !res_valid_q || result_ready;
	assign push     = (cmd.emit && hold_valid_q) || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.emit) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				hold_valid_q <= 1'b0;
			end
			if (push) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hold_act_q <= em_act;
			hold_grp_q <= em_grp;
			hold_msk_q <= em_msk;
		end
		if (push) begin
			res_act_q  <= hold_act_q;
			res_grp_q  <= hold_grp_q;
			res_msk_q  <= hold_msk_q;
			res_cnt_q  <= fgwt_pkg::count_bits(hold_msk_q);
			res_last_q <= cmd.finish;
		end
	end

	assign status.flush    = op_q;
	assign status.stale    = stale;
	assign status.finished = !hit && fin_raw;
	assign status.evict    = evict;
	assign status.full_any = |full_vec;
	assign status.empty    = (cnt_q == '0);
	assign status.can_emit = !hold_valid_q || out_free;
	assign status.out_free = out_free;

	assign result_valid  = res_valid_q;
	assign action        = res_act_q;
	assign result_group  = res_grp_q;
	assign present_mask  = res_msk_q;
	assign present_count = res_cnt_q;
	assign last          = res_last_q;

endmodule

[src/fec_group_window_tracker.sv]
// flow: one item at a time; a dropped packet goes through check and finish,
// a stored packet through check, store, evictions, full releases and finish,
// a flush through check, one word per open group, flush done and finish;
// the sequencer issues at most one result word per cycle
// reset: arst_n clears the table count, newest id, finished window and all handshakes
// ----------------------------------------------------------------------------
// fec_group_window_tracker
// tracks fec groups of received packets in a small sorted window, drops stale
// and finished packets, and releases or discards groups as the window moves
// ----------------------------------------------------------------------------
module fec_group_window_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	// item side
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic                           operation,
	input  logic [fgwt_pkg::GROUP_W-1:0]   packet_group,
	input  logic [fgwt_pkg::IDX_W-1:0]     packet_index,
	// result side
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [fgwt_pkg::ACT_W-1:0]     action,
	output logic [fgwt_pkg::GROUP_W-1:0]   result_group,
	output logic [fgwt_pkg::MASK_W-1:0]    present_mask,
	output logic [fgwt_pkg::COUNT_W-1:0]   present_count,
	output logic                           last
);

	// controller to datapath: one command set per cycle
	fgwt_pkg::cmd_t    cmd;
	// datapath to controller: table and handshake conditions
	fgwt_pkg::status_t status;

	// sequencer
	// idle -> check -> drop word, or table update -> stored word
	//      -> evictions oldest first -> full releases -> finish (last word)
	// flush: idle -> check -> one word per open group -> flush done -> finish
	fgwt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// table, finished window and output stage
	// each new word parks in a hold stage and moves to the output register when
	// the next word or the end of the item arrives, so that last can be set
	fgwt_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.operation     (operation),
		.packet_group  (packet_group),
		.packet_index  (packet_index),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.action        (action),
		.result_group  (result_group),
		.present_mask  (present_mask),
		.present_count (present_count),
		.last          (last)
	);

endmodule

[src/fgwt_checker.sv]
// ----------------------------------------------------------------------------
// fgwt_checker
// port-level checks on the tracker's handshakes and word sequencing
// ----------------------------------------------------------------------------
`include "fec_group_window_tracker_defines.svh"

module fgwt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_valid,
	input logic                           item_ready,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic [fgwt_pkg::ACT_W-1:0]     action,
	input logic [fgwt_pkg::GROUP_W-1:0]   result_group,
	input logic [fgwt_pkg::MASK_W-1:0]    present_mask,
	input logic [fgwt_pkg::COUNT_W-1:0]   present_count,
	input logic                           last
);

	// a stalled word holds
	`FGWT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(action) && $stable(result_group) && $stable(present_mask) && $stable(present_count) && $stable(last), "result word changed while stalled")

	// one item in flight at a time
	`FGWT_ASSERT_NEXT(a_one_item, item_valid && item_ready, !item_ready, "item taken while another is in flight")

	// when ready for a new item, only the final word of the previous one may wait
	`FGWT_ASSERT_NOW(a_idle_last, item_ready && result_valid, last, "non-final word pending while accepting items")

endmodule

bind fec_group_window_tracker fgwt_checker u_fgwt_checker (.*);

[verif/fec_group_window_tracker_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fec group window tracker testbench
// drives packet and flush words into the tracker, predicts every result word
// from its own copy of the group table and finished window, and checks the
// results in order under several idle and stall patterns
// ----------------------------------------------------------------------------

import fgwt_pkg::*;

typedef enum logic {
	OP_PACKET = 1'b0,
	OP_FLUSH  = 1'b1
} tracker_op_t;

typedef struct packed {
	action_t act;
	group_t  grp;
	mask_t   mask;
	count_t  cnt;
	logic    is_last;
} tracker_word_t;

class fec_window_scoreboard;
	bit                    slot_used [NSLOTS];
	group_t                slot_id   [NSLOTS];
	mask_t                 slot_bits [NSLOTS];
	group_t                newest_id;
	logic [MARK_DEPTH-1:0] done_marks;
	bit                    any_stored;
	tracker_word_t         expected_words [$];
	int                    errors;

	function new();
		for (int i = 0; i < NSLOTS; i++) begin
			slot_used[i] = 1'b0;
		end
		newest_id  = '0;
		done_marks = '0;
		any_stored = 1'b0;
		errors     = 0;
	endfunction

	function void push_word(action_t act, group_t grp, mask_t mask);
		tracker_word_t w;
		w.act     = act;
		w.grp     = grp;
		w.mask    = mask;
		w.cnt     = count_t'($countones(mask));
		w.is_last = 1'b0;
		expected_words.push_back(w);
	endfunction

	function void close_batch();
		expected_words[expected_words.size() - 1].is_last = 1'b1;
	endfunction

	function action_t close_action(mask_t m);
		return ($countones(m) >= CODE_K) ? ACT_RELEASED : ACT_DISCARDED;
	endfunction

	function void mark_done(group_t g);
		group_t d;
		if (!any_stored || g > newest_id)
			return;
		d = newest_id - g;
		if (d < MARK_DEPTH)
			done_marks[d] = 1'b1;
	endfunction

	function bit group_done(group_t g);
		group_t d;
		if (!any_stored || g > newest_id)
			return 1'b0;
		d = newest_id - g;
		if (d >= MARK_DEPTH)
			return 1'b1;
		return done_marks[d];
	endfunction

	function void note_word(tracker_op_t op, group_t gid, logic [IDX_W-1:0] idx);
		group_t tg [NWORK];
		mask_t  tm [NWORK];
		int     tn, pos, i, j;
		group_t d;
		tn = 0;
		for (i = 0; i < NSLOTS; i++) begin
			if (slot_used[i]) begin
				j = tn;
				while (j > 0 && tg[j-1] > slot_id[i]) begin
					tg[j] = tg[j-1];
					tm[j] = tm[j-1];
					j--;
				end
				tg[j] = slot_id[i];
				tm[j] = slot_bits[i];
				tn++;
			end
		end

		if (op == OP_FLUSH) begin
			for (i = 0; i < tn; i++) begin
				push_word(close_action(tm[i]), tg[i], tm[i]);
				mark_done(tg[i]);
			end
			for (i = 0; i < NSLOTS; i++) begin
				slot_used[i] = 1'b0;
			end
			push_word(ACT_FLUSH_DONE, '0, '0);
			close_batch();
			return;
		end

		if (tn >= WINDOW_GROUPS && tn > 0 && gid < tg[0]) begin
			push_word(ACT_DROP_STALE, gid, '0);
			close_batch();
			return;
		end
		pos = -1;
		for (i = 0; i < tn; i++) begin
			if (tg[i] == gid)
				pos = i;
		end
		if (pos < 0 && group_done(gid)) begin
			push_word(ACT_DROP_FINISHED, gid, '0);
			close_batch();
			return;
		end

		if (!any_stored || gid > newest_id) begin
			d = gid - newest_id;
			if (!any_stored || d >= MARK_DEPTH)
				done_marks = '0;
			else
				done_marks = done_marks << d;
			newest_id  = gid;
			any_stored = 1'b1;
		end

		if (pos < 0) begin
			j = tn;
			while (j > 0 && tg[j-1] > gid) begin
				tg[j] = tg[j-1];
				tm[j] = tm[j-1];
				j--;
			end
			tg[j] = gid;
			tm[j] = '0;
			tn++;
			pos = j;
		end
		tm[pos][idx] = 1'b1;
		push_word(ACT_STORED, gid, tm[pos]);

		while (tn > 1 && (tg[tn-1] - tg[0]) > group_t'(WINDOW_GROUPS)) begin
			push_word(close_action(tm[0]), tg[0], tm[0]);
			mark_done(tg[0]);
			for (j = 1; j < tn; j++) begin
				tg[j-1] = tg[j];
				tm[j-1] = tm[j];
			end
			tn--;
		end

		i = 0;
		while (i < tn) begin
			if ($countones(tm[i]) >= CODE_N) begin
				push_word(ACT_RELEASED, tg[i], tm[i]);
				mark_done(tg[i]);
				for (j = i + 1; j < tn; j++) begin
					tg[j-1] = tg[j];
					tm[j-1] = tm[j];
				end
				tn--;
			end else begin
				i++;
			end
		end

		for (i = 0; i < NSLOTS; i++) begin
			slot_used[i] = (i < tn);
			if (i < tn) begin
				slot_id[i]   = tg[i];
				slot_bits[i] = tm[i];
			end
		end
		close_batch();
	endfunction

	function void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			errors++;
		end
	endfunction

	function void check_word(logic [ACT_W-1:0] act, group_t grp, mask_t mask,
			count_t cnt, logic is_last);
		tracker_word_t w;
		if (expected_words.size() == 0) begin
			$display("%0t: result word with none expected, got action %0d group %h mask %h",
				$time, act, grp, mask);
			errors++;
			return;
		end
		w = expected_words.pop_front();
		compare_field("action", 32'(w.act), 32'(act));
		compare_field("result_group", w.grp, grp);
		compare_field("present_mask", 32'(w.mask), 32'(mask));
		compare_field("present_count", 32'(w.cnt), 32'(cnt));
		compare_field("last", 32'(w.is_last), 32'(is_last));
	endfunction

	function int pending();
		return expected_words.size();
	endfunction
endclass

module fec_group_window_tracker_test;

	// cycles with no word moving on either side before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// quiet cycles after the last expected word, to catch stray results
	localparam int TAIL_CYCLES = 24;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_ready;
	logic                 operation    = 1'b0;
	group_t               packet_group = '0;
	logic [IDX_W-1:0]     packet_index = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [ACT_W-1:0]     action;
	group_t               result_group;
	mask_t                present_mask;
	count_t               present_count;
	logic                 last;

	fec_window_scoreboard tracker_sb;
	int                   send_idle_pct  = 0;
	int                   recv_stall_pct = 0;
	int                   quiet_cycles   = 0;
	int                   words_sent     = 0;
	group_t               base_group;

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	fec_group_window_tracker uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.operation     (operation),
		.packet_group  (packet_group),
		.packet_index  (packet_index),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.action        (action),
		.result_group  (result_group),
		.present_mask  (present_mask),
		.present_count (present_count),
		.last          (last)
	);

	// receiver stalls at random, one fresh decision per cycle
	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// handshake monitor: values seen here are the ones held before the edge,
	// so the word counts as moved exactly when the block takes it
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				tracker_sb.note_word(tracker_op_t'(operation), packet_group, packet_index);
			if (result_valid && result_ready)
				tracker_sb.check_word(action, result_group, present_mask, present_count, last);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			// nothing moving for far longer than any correct run allows
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// one word into the block; gaps are random idle cycles with valid low,
	// and with no gap valid stays high straight into the next word
	task automatic send_word(input tracker_op_t op, input group_t gid,
			input logic [IDX_W-1:0] idx);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		operation    <= op;
		packet_group <= gid;
		packet_index <= idx;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// hold the sender off until every predicted word has come back;
	// the queue is looked at on the falling edge, away from the monitor
	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (tracker_sb.pending() != 0);
		@(posedge clk);
	endtask

	// mostly well-formed traffic: bursts of shuffled indices over a few
	// neighbouring groups with a slowly moving base, plus flushes, late
	// packets around the finished window and jumps to random ids
	task automatic run_random(input int count);
		int     stop_at, r, k, i, tmp, burst_len;
		int     perm [MASK_W];
		group_t gid;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				// flush with junk in the unused fields
				send_word(OP_FLUSH, $urandom, IDX_W'($urandom));
			end else if (r < 10) begin
				// jump anywhere in the id space and carry on from there
				base_group = $urandom;
				send_word(OP_PACKET, base_group, IDX_W'($urandom));
			end else if (r < 18) begin
				// late packet: stale, finished, or still open
				send_word(OP_PACKET, base_group - $urandom_range(1, 70), IDX_W'($urandom));
			end else begin
				gid = base_group + $urandom_range(0, 2);
				k = $urandom_range(0, 9);
				if (k < 6)
					burst_len = MASK_W;
				else if (k < 8)
					burst_len = $urandom_range(CODE_K, MASK_W - 1);
				else
					burst_len = $urandom_range(1, CODE_K - 1);
				for (i = 0; i < MASK_W; i++)
					perm[i] = i;
				for (i = MASK_W - 1; i > 0; i--) begin
					k = $urandom_range(0, i);
					tmp = perm[i];
					perm[i] = perm[k];
					perm[k] = tmp;
				end
				for (i = 0; i < burst_len; i++) begin
					r = $urandom_range(0, 99);
					if (r < 15)
						// interleave a packet of a newer neighbour
						send_word(OP_PACKET, gid + $urandom_range(1, 4), IDX_W'($urandom));
					else if (r < 20)
						// any index, duplicates allowed
						send_word(OP_PACKET, gid, IDX_W'($urandom));
					else
						send_word(OP_PACKET, gid, IDX_W'(perm[i]));
				end
				// creep forward, now and then far enough to force evictions
				k = $urandom_range(0, 9);
				base_group = base_group + ((k < 8) ? $urandom_range(0, 2) : $urandom_range(5, 8));
			end
		end
	endtask

	initial begin
		int ph;
		tracker_sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		send_word(OP_FLUSH, 32'h0000_0000, 3'd0);      // flush of an empty table
		send_word(OP_PACKET, 32'h0000_0000, 3'd0);     // first store ever
		send_word(OP_PACKET, 32'h0000_0000, 3'd7);
		send_word(OP_PACKET, 32'h0000_0000, 3'd7);     // duplicate index
		send_word(OP_PACKET, 32'h0000_0000, 3'd1);
		send_word(OP_PACKET, 32'h0000_0000, 3'd2);
		send_word(OP_PACKET, 32'h0000_0000, 3'd3);
		send_word(OP_PACKET, 32'h0000_0000, 3'd4);
		send_word(OP_PACKET, 32'h0000_0000, 3'd5);
		send_word(OP_PACKET, 32'h0000_0000, 3'd6);     // group complete, released
		send_word(OP_PACKET, 32'h0000_0000, 3'd2);     // finished group
		send_word(OP_PACKET, 32'h0000_0001, 3'd0);
		send_word(OP_PACKET, 32'h0000_0002, 3'd0);
		send_word(OP_PACKET, 32'h0000_0003, 3'd0);
		send_word(OP_PACKET, 32'h0000_0004, 3'd0);     // table now full enough
		send_word(OP_PACKET, 32'h0000_0000, 3'd3);     // stale, below the oldest
		send_word(OP_PACKET, 32'h0000_0006, 3'd5);     // evicts the oldest group
		send_word(OP_FLUSH, 32'hFFFF_FFFF, 3'd7);      // discards everything open
		send_word(OP_PACKET, 32'h0000_0003, 3'd0);     // marked finished by the flush
		send_word(OP_PACKET, 32'hFFFF_FFFF, 3'd7);     // far jump clears the window
		send_word(OP_PACKET, 32'hFFFF_FFBF, 3'd4);     // just outside the window
		send_word(OP_PACKET, 32'hFFFF_FFC0, 3'd1);     // inside, then evicted at once
		send_word(OP_PACKET, 32'h8000_0000, 3'd6);     // far below the newest
		send_word(OP_FLUSH, 32'h0000_0000, 3'd0);
		wait_drained();

		// random part in four idling phases, draining between them
		base_group = $urandom_range(0, 1000);
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 58;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 58;
				end
				default: begin
					send_idle_pct  = 7;
					recv_stall_pct = 7;
				end
			endcase
			run_random(80);
			wait_drained();
		end

		// let any stray result words show up
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker_sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
